@@ design/tlbprw_pkg.sv @@
// Shared types, constants and helpers for the TLB probe/read/write block.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package tlbprw_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int VPN2_W      = 29;
	localparam int ASID_W      = 8;
	localparam int MASK_W      = 19;   // PageMask bits 31:13
	localparam int OP_W        = 2;
	localparam int INDEX_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PROBE = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// Entry update request handed to the tag store
	typedef struct packed {
		logic               en;
		logic [INDEX_W-1:0] index;
		logic [63:0]        hi_word;
		logic [31:0]        size_mask;
		logic               lo0_global;
		logic               lo1_global;
	} wr_req_t;

	// Gather VPN2: address bits 63:62 to 28:27, bits 39:13 to 26:0
	function automatic logic [VPN2_W-1:0] form_vpn2(input logic [63:0] a);
		form_vpn2 = {a[63:62], a[39:13]};
	endfunction

endpackage

@@ design/tlbprw_store.sv @@
// Tag store: per-entry VPN2, inverted page mask, ASID and global flag,
// with the parallel probe compare and one indexed read port. Uses tlbprw_pkg.
`timescale 1ns / 1ps

module tlbprw_store #(
	parameter int ENTRIES = tlbprw_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlbprw_pkg::wr_req_t                 wr,
	input  logic [tlbprw_pkg::INDEX_W-1:0]      rd_index,
	input  logic [tlbprw_pkg::VPN2_W-1:0]       probe_vpn,
	input  logic [tlbprw_pkg::ASID_W-1:0]       probe_asid,
	output logic [ENTRIES-1:0]                  match,
	output logic [63:0]                         rd_hi
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [tlbprw_pkg::VPN2_W-1:0] vpn_q    [ENTRIES];
	logic [tlbprw_pkg::MASK_W-1:0] mask_q   [ENTRIES];
	logic [tlbprw_pkg::ASID_W-1:0] asid_q   [ENTRIES];
	logic [ENTRIES-1:0]            global_q;
	logic [ENTRIES-1:0]            written_q;

	logic             wr_ok;
	logic             rd_ok;
	logic [IDX_W-1:0] wr_sel;
	logic [IDX_W-1:0] rd_sel;

	assign wr_ok  = {27'd0, wr.index} < 32'(ENTRIES);
	assign rd_ok  = {27'd0, rd_index} < 32'(ENTRIES);
	assign wr_sel = IDX_W'(wr.index);
	assign rd_sel = IDX_W'(rd_index);

	// Reset entries hold an all-ones VPN2 and never match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) begin
				vpn_q[k]  <= '1;
				mask_q[k] <= '0;
				asid_q[k] <= '0;
			end
			global_q  <= '0;
			written_q <= '0;
		end else if (wr.en && wr_ok) begin
			vpn_q[wr_sel]     <= tlbprw_pkg::form_vpn2(wr.hi_word);
			mask_q[wr_sel]    <= ~wr.size_mask[31:13];
			asid_q[wr_sel]    <= wr.hi_word[tlbprw_pkg::ASID_W-1:0];
			global_q[wr_sel]  <= wr.lo0_global & wr.lo1_global;
			written_q[wr_sel] <= 1'b1;
		end
	end

	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			match[k] = written_q[k]
				&& ((probe_vpn & {10'h3FF, mask_q[k]}) == vpn_q[k])
				&& (global_q[k] || (asid_q[k] == probe_asid));
		end
	end

	always_comb begin
		rd_hi = '0;
		if (rd_ok) begin
			rd_hi = {vpn_q[rd_sel][28:27], 22'd0, vpn_q[rd_sel][26:0],
				global_q[rd_sel], 4'd0, asid_q[rd_sel]};
		end
	end

endmodule

@@ design/tlbprw_encode.sv @@
// Lowest-index priority encoder over the probe match vector.
// Depends on tlbprw_pkg for the default entry count.
`timescale 1ns / 1ps

module tlbprw_encode #(
	parameter int ENTRIES = tlbprw_pkg::ENTRIES_DEF
) (
	input  logic [ENTRIES-1:0]         match,
	output logic                       hit,
	output logic [$clog2(ENTRIES)-1:0] index
);

	localparam int IDX_W = $clog2(ENTRIES);

	assign hit = |match;

	always_comb begin
		index = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (match[k]) begin
				index = IDX_W'(k);
			end
		end
	end

endmodule

@@ design/tlb_probe_read_write.sv @@
// Top level of the TLB probe/read/write block: input register, tag store,
// priority encoder and result register. Uses tlbprw_pkg, tlbprw_store, tlbprw_encode.
`timescale 1ns / 1ps

// Usage
//   Request channel: in_valid/in_stall with operation, vaddr, probe_asid,
//   entry_index, hi_word, lo0_global, lo1_global and size_mask. A request
//   is taken at a rising edge with in_valid high and in_stall low.
//   Result channel: out_valid/out_stall with miss, hit_index and read_hi.
//   Every request, whatever its operation, yields exactly one result.
//   Path: a request is held in the request register and then its result
//   in the result register, which drives out_valid. Throughput: one
//   request per cycle while out_stall is low; the request register and
//   the result register are the only stages, and all ENTRIES tag compares
//   plus the priority encode run in parallel between them.
//   A write updates the store as it leaves the request register, so the
//   very next request already sees the new entry.
//   Stall: while out_stall holds a waiting result, the request register
//   still fills once; in_stall then rises until the result is taken.
//   Reset: arst_n clears both valid flags and returns every entry to its
//   reset state (VPN2 all ones and not matchable, mask, ASID, global zero).

module tlb_probe_read_write #(
	parameter int ENTRIES = tlbprw_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [63:0] vaddr,
	input  logic [7:0]  probe_asid,
	input  logic [4:0]  entry_index,
	input  logic [63:0] hi_word,
	input  logic        lo0_global,
	input  logic        lo1_global,
	input  logic [31:0] size_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        miss,
	output logic [4:0]  hit_index,
	output logic [63:0] read_hi
);

	localparam int IDX_W = $clog2(ENTRIES);

	// Request register
	logic                valid_s1;
	tlbprw_pkg::op_t     op_s1;
	logic [63:0]         vaddr_s1;
	logic [7:0]          asid_s1;
	logic [4:0]          index_s1;
	logic [63:0]         hi_s1;
	logic                g0_s1;
	logic                g1_s1;
	logic [31:0]         mask_s1;

	// Result register
	logic                valid_s2;
	logic                miss_s2;
	logic [4:0]          hit_s2;
	logic [63:0]         rhi_s2;

	logic                in_take;
	logic                adv;
	tlbprw_pkg::wr_req_t wr;
	logic [ENTRIES-1:0]  match;
	logic                hit;
	logic [IDX_W-1:0]    enc_index;
	logic [63:0]         rd_hi;
	logic                miss_d;
	logic [4:0]          hit_d;
	logic [63:0]         rhi_d;

	// Advance the request whenever the result slot is empty or draining
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= tlbprw_pkg::op_t'(operation);
			vaddr_s1 <= vaddr;
			asid_s1  <= probe_asid;
			index_s1 <= entry_index;
			hi_s1    <= hi_word;
			g0_s1    <= lo0_global;
			g1_s1    <= lo1_global;
			mask_s1  <= size_mask;
		end
	end

	// Commit a write only as its request leaves the register
	always_comb begin
		wr.en         = adv && (op_s1 == tlbprw_pkg::OP_WRITE);
		wr.index      = index_s1;
		wr.hi_word    = hi_s1;
		wr.size_mask  = mask_s1;
		wr.lo0_global = g0_s1;
		wr.lo1_global = g1_s1;
	end

	tlbprw_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.rd_index   (index_s1),
		.probe_vpn  (tlbprw_pkg::form_vpn2(vaddr_s1)),
		.probe_asid (asid_s1),
		.match      (match),
		.rd_hi      (rd_hi)
	);

	tlbprw_encode #(
		.ENTRIES (ENTRIES)
	) u_encode (
		.match (match),
		.hit   (hit),
		.index (enc_index)
	);

	// Shape the result; unused operation code yields all zeros
	always_comb begin
		miss_d = 1'b0;
		hit_d  = '0;
		rhi_d  = '0;
		case (op_s1)
			tlbprw_pkg::OP_PROBE: begin
				miss_d = !hit;
				hit_d  = hit ? 5'(enc_index) : 5'd0;
			end
			tlbprw_pkg::OP_READ: begin
				rhi_d = rd_hi;
			end
			tlbprw_pkg::OP_WRITE: begin
				rhi_d = '0;
			end
			default: begin
				rhi_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_s2 <= miss_d;
			hit_s2  <= hit_d;
			rhi_s2  <= rhi_d;
		end
	end

	assign out_valid = valid_s2;
	assign miss      = miss_s2;
	assign hit_index = hit_s2;
	assign read_hi   = rhi_s2;

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("request side stalled with an empty request register");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced request produced no result");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && miss_s2) |-> (hit_s2 == 5'd0 && rhi_s2 == 64'd0))
		else $error("miss result carries a nonzero index or EntryHi");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == tlbprw_pkg::OP_WRITE) |=>
		(!miss_s2 && hit_s2 == 5'd0 && rhi_s2 == 64'd0))
		else $error("write request produced a nonzero result");

endmodule

@@ test/tb.sv @@
// Self-checking bench for the TLB probe/read/write block: probe, read, write and spare-code requests.
// Predicts every result in-bench and checks it; depends on tlbprw_pkg and tlb_probe_read_write.
`timescale 1ns / 1ps

module tb;

	// Operation code that the block leaves unused: it must change nothing
	// and return an all-zero result.
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam int N_ENTRIES      = 32;
	localparam int RANDOM_REQS    = 400;
	localparam int LONG_HOLD      = 80;    // receiver hold-off, in cycles
	localparam int DRAIN_CYCLES   = 8;     // settle time after the last result
	localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all

	typedef struct {
		logic [1:0]  op;
		logic [63:0] vaddr;
		logic [7:0]  asid;
		logic [4:0]  idx;
		logic [63:0] hi;
		logic        g0;
		logic        g1;
		logic [31:0] pm;
		bit          drain_first;  // wait for all results before sending
	} tlb_req_t;

	typedef struct {
		logic        miss;
		logic [4:0]  idx;
		logic [63:0] hi;
	} tlb_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [63:0] vaddr = '0;
	logic [7:0]  probe_asid = '0;
	logic [4:0]  entry_index = '0;
	logic [63:0] hi_word = '0;
	logic        lo0_global = 1'b0;
	logic        lo1_global = 1'b0;
	logic [31:0] size_mask = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        miss;
	logic [4:0]  hit_index;
	logic [63:0] read_hi;

	tlb_probe_read_write u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.vaddr      (vaddr),
		.probe_asid (probe_asid),
		.entry_index(entry_index),
		.hi_word    (hi_word),
		.lo0_global (lo0_global),
		.lo1_global (lo1_global),
		.size_mask  (size_mask),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.miss       (miss),
		.hit_index  (hit_index),
		.read_hi    (read_hi)
	);

	// 4 ns period clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// ------------------------------------------------------------------
	// Predicted TLB contents. These mirror the block's tag store and are
	// updated as each request is accepted, so results follow request order.
	// ------------------------------------------------------------------
	logic [31:0] tag_vpn  [N_ENTRIES];
	logic [31:0] tag_mask [N_ENTRIES];
	logic        tag_glob [N_ENTRIES];
	logic [7:0]  tag_asid [N_ENTRIES];

	initial begin
		// Reset contents: VPN2 all ones can never equal a 29-bit VPN2
		for (int k = 0; k < N_ENTRIES; k++) begin
			tag_vpn[k]  = 32'hFFFF_FFFF;
			tag_mask[k] = '0;
			tag_glob[k] = 1'b0;
			tag_asid[k] = '0;
		end
	end

	// Gather VPN2 out of an address: bits 63:62 land at 28:27, 39:13 at 26:0
	function automatic logic [31:0] addr_vpn2(input logic [63:0] a);
		return 32'((a >> 35) & 64'h1800_0000) | 32'((a >> 13) & 64'h07FF_FFFF);
	endfunction

	// Apply one request to the predicted store and return its result
	function automatic tlb_result_t tlb_execute(input tlb_req_t r);
		tlb_result_t res;
		logic [31:0] v;
		logic [63:0] e;
		bit found;
		res = '{miss: 1'b0, idx: '0, hi: '0};
		found = 0;
		case (r.op)
			tlbprw_pkg::OP_PROBE: begin
				v = addr_vpn2(r.vaddr);
				// Lowest matching entry wins; the stored VPN2 is not masked
				for (int k = 0; k < N_ENTRIES; k++) begin
					if (!found && (v & tag_mask[k]) == tag_vpn[k] &&
					    (tag_glob[k] || tag_asid[k] == r.asid)) begin
						found = 1;
						res.idx = 5'(k);
					end
				end
				res.miss = !found;
			end
			tlbprw_pkg::OP_READ: begin
				e = {32'b0, tag_vpn[r.idx]};
				res.hi = ((e & 64'h1800_0000) << 35) | ((e & 64'h07FF_FFFF) << 13) |
					(64'(tag_glob[r.idx]) << 12) | 64'(tag_asid[r.idx]);
			end
			tlbprw_pkg::OP_WRITE: begin
				tag_mask[r.idx] = ~(r.pm >> 13);
				tag_vpn[r.idx]  = addr_vpn2(r.hi);
				tag_glob[r.idx] = r.g0 & r.g1;
				tag_asid[r.idx] = r.hi[7:0];
			end
			default: ;  // spare code: no state change, zero result
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request generation. A light shadow of what has been written lets
	// probes aim at live entries instead of missing almost every time.
	// ------------------------------------------------------------------
	tlb_req_t    req_queue[$];
	tlb_result_t pending_results[$];
	logic [63:0] gen_hi   [N_ENTRIES];
	logic [31:0] gen_pm   [N_ENTRIES];
	bit          gen_used [N_ENTRIES];
	bit          drain_next = 0;
	int          mismatches = 0;
	int          results_seen = 0;

	task automatic queue_req(input logic [1:0] op, input logic [63:0] va,
		input logic [7:0] asid, input logic [4:0] idx, input logic [63:0] hi,
		input logic g0, input logic g1, input logic [31:0] pm);
		tlb_req_t r;
		r = '{op: op, vaddr: va, asid: asid, idx: idx, hi: hi, g0: g0, g1: g1,
			pm: pm, drain_first: drain_next};
		drain_next = 0;
		req_queue.push_back(r);
		if (op == tlbprw_pkg::OP_WRITE) begin
			gen_hi[idx]   = hi;
			gen_pm[idx]   = pm;
			gen_used[idx] = 1;
		end
	endtask

	// Address that hits entry k: keep its VPN2 bits, randomize the rest
	// (bits 61:40, the page offset and anything under the page mask).
	function automatic logic [63:0] aim_at_entry(input int k, input logic [63:0] noise);
		logic [63:0] dont_care;
		dont_care = 64'h3FFF_FF00_0000_1FFF | {32'b0, gen_pm[k] & 32'hFFFF_E000};
		return (gen_hi[k] & ~dont_care) | (noise & dont_care);
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got %h, want %h (t=%0t)", what, got, want, $realtime);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int op_pick;
		int k;
		logic [1:0]  op;
		logic [63:0] va;
		logic [63:0] hi;
		logic [7:0]  asid;
		logic [4:0]  idx;
		logic [1:0]  glob;
		logic [31:0] pm;

		// Directed: reset contents, then hits, priority, global and masks
		queue_req(tlbprw_pkg::OP_PROBE, '0, 8'h00, 5'd0, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_PROBE, '1, 8'hFF, 5'd31, '1, 1'b1, 1'b1, '1);
		queue_req(tlbprw_pkg::OP_READ, '0, '0, 5'd0, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_READ, '1, '1, 5'd31, '1, 1'b1, 1'b1, '1);
		// Private entry: hits only with its own ASID
		queue_req(tlbprw_pkg::OP_WRITE, '0, '0, 5'd5, 64'h4000_0024_68AC_E03C,
			1'b1, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_PROBE, 64'h4000_0024_68AC_E03C, 8'h3C, '0, '0,
			1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_PROBE, 64'h4000_0024_68AC_E03C, 8'h3D, '0, '0,
			1'b0, 1'b0, '0);
		// Same tag in a lower slot takes priority
		queue_req(tlbprw_pkg::OP_WRITE, '0, '0, 5'd2, 64'h4000_0024_68AC_E03C,
			1'b0, 1'b1, '0);
		queue_req(tlbprw_pkg::OP_PROBE, 64'h4000_0024_68AC_FFFF, 8'h3C, '0, '0,
			1'b0, 1'b0, '0);
		// Largest mask with VPN2 bits set under it: can never hit
		queue_req(tlbprw_pkg::OP_WRITE, '0, '0, 5'd31, '1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		queue_req(tlbprw_pkg::OP_PROBE, '1, 8'h55, '0, '0, 1'b0, 1'b0, '0);
		// Same mask with clean low bits, global: hits with any ASID
		queue_req(tlbprw_pkg::OP_WRITE, '0, '0, 5'd30, 64'hC000_00FF_0000_0000,
			1'b1, 1'b1, 32'hFFFF_FFFF);
		queue_req(tlbprw_pkg::OP_PROBE, '1, 8'h55, '0, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_READ, '0, '0, 5'd30, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_READ, '0, '0, 5'd31, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_READ, '0, '0, 5'd5, '0, 1'b0, 1'b0, '0);
		// All-zero entry in slot 0
		queue_req(tlbprw_pkg::OP_WRITE, '1, '1, 5'd0, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_PROBE, '0, 8'h00, '0, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_PROBE, '0, 8'h01, '0, '0, 1'b0, 1'b0, '0);
		queue_req(tlbprw_pkg::OP_READ, '0, '0, 5'd0, '0, 1'b0, 1'b0, '0);
		// Spare opcode, with every field high and then low
		queue_req(OP_SPARE, '1, '1, '1, '1, 1'b1, 1'b1, '1);
		queue_req(OP_SPARE, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		// Typical 16K page mask
		queue_req(tlbprw_pkg::OP_WRITE, '0, '0, 5'd17, 64'h8000_0012_3454_0001,
			1'b1, 1'b1, 32'h0000_6000);
		queue_req(tlbprw_pkg::OP_PROBE, aim_at_entry(17, '1), 8'hAA, '0, '0,
			1'b0, 1'b0, '0);

		// Random: probes (many aimed at live entries), plus reads, writes
		// with realistic page masks, and some noise
		for (int n = 0; n < RANDOM_REQS; n++) begin
			op_pick = $urandom_range(0, 99);
			va   = {$urandom, $urandom};
			hi   = {$urandom, $urandom};
			asid = 8'($urandom);
			idx  = 5'($urandom);
			glob = 2'($urandom);
			pm   = $urandom;
			if (n == 0 || n == RANDOM_REQS / 2)
				drain_next = 1;
			if (op_pick < 5) begin
				op = OP_SPARE;
			end else if (op_pick < 50) begin
				op = tlbprw_pkg::OP_PROBE;
				k = $urandom_range(0, N_ENTRIES - 1);
				if (gen_used[k] && $urandom_range(0, 9) < 7) begin
					va = aim_at_entry(k, va);
					if ($urandom_range(0, 1) == 1)
						asid = gen_hi[k][7:0];
				end
			end else if (op_pick < 68) begin
				op = tlbprw_pkg::OP_READ;
			end else begin
				op = tlbprw_pkg::OP_WRITE;
				// Legal page sizes: 0, 3, 0xF ... 0xFFF shifted up to bit 13
				if ($urandom_range(0, 9) < 6)
					pm = ((32'd1 << (2 * $urandom_range(0, 6))) - 32'd1) << 13;
				// Clear VPN2 bits under the mask so that the entry can hit
				if ($urandom_range(0, 1) == 1)
					hi = hi & ~{32'b0, pm & 32'hFFFF_E000};
			end
			queue_req(op, va, asid, idx, hi, glob[1], glob[0], pm);
		end

		// Hold reset, then release it at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every result to come out
		wait (req_queue.size() == 0 && !in_valid && pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request driver: bursts of random length with random gaps; a
	// request marked drain_first waits until no result is outstanding.
	// ------------------------------------------------------------------
	logic req_took = 1'b0;  // request accepted at the last rising edge
	int   burst_left = 0;
	int   gap_left = 0;
	int   sent_count = 0;

	always @(negedge clk) begin
		tlb_req_t r;
		if (arst_n) begin
			if (in_valid && !req_took) begin
				// hold the stalled request
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (req_queue.size() > 0 &&
			             !(req_queue[0].drain_first && pending_results.size() != 0)) begin
				r = req_queue.pop_front();
				operation   <= r.op;
				vaddr       <= r.vaddr;
				probe_asid  <= r.asid;
				entry_index <= r.idx;
				hi_word     <= r.hi;
				lo0_global  <= r.g0;
				lo1_global  <= r.g1;
				size_mask   <= r.pm;
				in_valid    <= 1'b1;
				sent_count++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					// every third stretch of 64 requests runs with no gaps
					gap_left = ((sent_count / 64) % 3 == 2) ? 0 : $urandom_range(0, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: stall pattern that steps through four modes, plus
	// one long hold-off that lets the block fill and stall its input.
	// ------------------------------------------------------------------
	int rx_phase = 0;
	int stall_left = 0;
	bit long_hold_done = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			rx_phase++;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!long_hold_done && results_seen >= 120) begin
				long_hold_done = 1;
				stall_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				case ((rx_phase / 50) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= (rx_phase % 3 == 0);
					2: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check results against the oldest prediction first, then
	// predict the request accepted at this edge.
	// ------------------------------------------------------------------
	tlb_req_t    seen_req;
	tlb_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_took <= 1'b0;
		end else begin
			req_took <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					note_mismatch("result with nothing outstanding", read_hi, '0);
				end else begin
					want = pending_results.pop_front();
					if (miss !== want.miss)
						note_mismatch("miss", 64'(miss), 64'(want.miss));
					if (hit_index !== want.idx)
						note_mismatch("hit_index", 64'(hit_index), 64'(want.idx));
					if (read_hi !== want.hi)
						note_mismatch("read_hi", read_hi, want.hi);
				end
			end
			if (in_valid && !in_stall) begin
				seen_req = '{op: operation, vaddr: vaddr, asid: probe_asid,
					idx: entry_index, hi: hi_word, g0: lo0_global, g1: lo1_global,
					pm: size_mask, drain_first: 0};
				pending_results.push_back(tlb_execute(seen_req));
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if neither channel moves for too long
	// ------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

@@ filelist.f @@
design/tlbprw_pkg.sv
design/tlbprw_store.sv
design/tlbprw_encode.sv
design/tlb_probe_read_write.sv
test/tb.sv
